@@ rtl/core/lsf_pkg.sv @@
package lsf_pkg;

	localparam int unsigned PAT_BYTES   = 16;
	localparam int unsigned PLEN_W      = 5;
	localparam int unsigned LINE_LEN_W  = 10;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned APB_ADDR_W  = 5;
	localparam int unsigned APB_DATA_W  = 64;
	localparam int unsigned S_DATA_W    = 8;
	localparam int unsigned M_DATA_W    = 32;

	localparam logic [7:0]         NEWLINE_BYTE = 8'h0A;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2,
		REG_INVERT_MATCH   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] pattern;
		logic [PLEN_W-1:0]         pattern_length;
		logic                      invert_match;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0]    selected_count;
		logic                  line_selected;
		logic                  pattern_found;
		logic [LINE_LEN_W-1:0] line_length;
	} result_t;

endpackage

@@ rtl/core/literal_substring_line_filter_top.sv @@
// A word accepted on s_* passes the input register, then the result register, before the
// verdict for its line shows on m_*; a verdict held on m_* stalls the input.
// Throughput: one word per cycle while no verdict is held on m_*; the match against all pattern lengths is one
// parallel compare of the current byte and the last PATTERN_MAX-1 bytes.
// Reset: arst_n clears the config registers, line state, selected count and both valid flags.
module literal_substring_line_filter_top #(
	parameter int unsigned LINE_LIMIT  = 512,
	parameter int unsigned PATTERN_MAX = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lsf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [lsf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [lsf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	// byte stream in
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lsf_pkg::S_DATA_W-1:0]       s_tdata,  // [7:0] data_byte
	input  logic                               s_tlast,  // flush
	// verdicts out
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lsf_pkg::M_DATA_W-1:0]       m_tdata   // [9:0] line_length, [10] pattern_found,
	                                                     // [11] line_selected,
	                                                     // [27:12] selected_count
);

	lsf_pkg::cfg_t     cfg;
	lsf_pkg::result_t  res;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              flush_s1;
	logic              advance;
	logic              res_valid;

	lsf_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata[7:0];
			flush_s1 <= s_tlast;
		end
	end

	lsf_line_engine #(
		.LINE_LIMIT  (LINE_LIMIT),
		.PATTERN_MAX (PATTERN_MAX)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (valid_s1),
		.item_byte    (byte_s1),
		.item_flush   (flush_s1),
		.item_advance (advance),
		.out_valid    (res_valid),
		.out_ready    (m_tready),
		.out_data     (res)
	);

	assign m_tvalid = res_valid;
	assign m_tdata  = lsf_pkg::M_DATA_W'(res);

endmodule

@@ rtl/core/lsf_apb_regs.sv @@
module lsf_apb_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lsf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [lsf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [lsf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	output lsf_pkg::cfg_t                      cfg
);

	logic [63:0]                    pattern_low_q;
	logic [63:0]                    pattern_high_q;
	logic [lsf_pkg::PLEN_W-1:0]     pattern_length_q;
	logic                           invert_match_q;
	lsf_pkg::reg_idx_t              reg_idx;
	logic                           wr_en;

	assign reg_idx = lsf_pkg::reg_idx_t'(paddr[4:3]);
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= '0;
			invert_match_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				lsf_pkg::REG_PATTERN_LOW:    pattern_low_q    <= pwdata;
				lsf_pkg::REG_PATTERN_HIGH:   pattern_high_q   <= pwdata;
				lsf_pkg::REG_PATTERN_LENGTH: pattern_length_q <= pwdata[lsf_pkg::PLEN_W-1:0];
				lsf_pkg::REG_INVERT_MATCH:   invert_match_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lsf_pkg::REG_PATTERN_LOW:    prdata = pattern_low_q;
			lsf_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_q;
			lsf_pkg::REG_PATTERN_LENGTH: prdata = lsf_pkg::APB_DATA_W'(pattern_length_q);
			lsf_pkg::REG_INVERT_MATCH:   prdata = lsf_pkg::APB_DATA_W'(invert_match_q);
			default:                     prdata = '0;
		endcase
	end

	assign cfg.pattern        = {pattern_high_q, pattern_low_q};
	assign cfg.pattern_length = pattern_length_q;
	assign cfg.invert_match   = invert_match_q;

endmodule

@@ rtl/core/lsf_match_unit.sv @@
module lsf_match_unit #(
	parameter int unsigned PATTERN_MAX = 16,
	parameter int unsigned CNT_W       = 10,
	parameter int unsigned WIN_D       = 15
) (
	input  lsf_pkg::cfg_t               cfg,
	input  logic [7:0]                  data_byte,
	input  logic [WIN_D-1:0][7:0]       window,
	input  logic [CNT_W-1:0]            line_count,
	output logic                        hit
);

	localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [PATTERN_MAX-1:0][7:0] cand;
	logic [PATTERN_MAX-1:0]      hit_len;
	logic [lsf_pkg::PLEN_W-1:0]  plen;
	logic [lsf_pkg::PLEN_W-1:0]  plen_m1;
	logic [IDX_W-1:0]            sel_idx;

	// cand[k] is the byte k places back, cand[0] the current one
	always_comb begin
		cand[0] = data_byte;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			cand[k] = window[k-1];
		end
	end

	// one match flag per possible pattern length, all in parallel
	always_comb begin
		for (int l = 1; l <= PATTERN_MAX; l++) begin
			hit_len[l-1] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (cand[k] != cfg.pattern[l-1-k]) begin
					hit_len[l-1] = 1'b0;
				end
			end
		end
	end

	assign plen    = (cfg.pattern_length > lsf_pkg::PLEN_W'(PATTERN_MAX))
	               ? lsf_pkg::PLEN_W'(PATTERN_MAX) : cfg.pattern_length;
	assign plen_m1 = plen - lsf_pkg::PLEN_W'(1);
	assign sel_idx = plen_m1[IDX_W-1:0];

	// all pattern bytes must lie inside the current line
	assign hit = (plen != '0) && (line_count >= CNT_W'(plen)) && hit_len[sel_idx];

endmodule

@@ rtl/core/lsf_line_engine.sv @@
module lsf_line_engine #(
	parameter int unsigned LINE_LIMIT  = 512,
	parameter int unsigned PATTERN_MAX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lsf_pkg::cfg_t     cfg,
	input  logic              item_valid,
	input  logic [7:0]        item_byte,
	input  logic              item_flush,
	output logic              item_advance,
	output logic              out_valid,
	input  logic              out_ready,
	output lsf_pkg::result_t  out_data
);

	localparam int unsigned CNT_W = $clog2(LINE_LIMIT + 1);
	localparam int unsigned WIN_D = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

	logic [CNT_W-1:0]           cnt_q;
	logic                       found_q;
	logic [lsf_pkg::COUNT_W-1:0] hit_total_q;
	logic [WIN_D-1:0][7:0]      window_q;
	logic                       out_valid_q;
	lsf_pkg::result_t           out_data_q;

	logic [CNT_W-1:0]           cnt_inc;
	logic                       hit;
	logic                       line_end;
	logic                       emit;
	logic                       found;
	logic                       sel;
	logic [lsf_pkg::COUNT_W-1:0] total_next;
	logic [CNT_W-1:0]           len_src;

	lsf_match_unit #(
		.PATTERN_MAX (PATTERN_MAX),
		.CNT_W       (CNT_W),
		.WIN_D       (WIN_D)
	) u_match (
		.cfg        (cfg),
		.data_byte  (item_byte),
		.window     (window_q),
		.line_count (cnt_inc),
		.hit        (hit)
	);

	assign item_advance = item_valid && (!out_valid_q || out_ready);
	assign cnt_inc      = cnt_q + CNT_W'(1);
	assign line_end     = item_flush ? (cnt_q != '0)
	                    : ((item_byte == lsf_pkg::NEWLINE_BYTE) ||
	                       (cnt_inc >= CNT_W'(LINE_LIMIT)));
	assign emit         = item_advance && line_end;

	// an empty pattern matches every line; flags taken at verdict time
	assign found      = found_q || (!item_flush && hit) || (cfg.pattern_length == '0);
	assign sel        = found ^ cfg.invert_match;
	assign total_next = (sel && hit_total_q != lsf_pkg::COUNT_MAX)
	                  ? hit_total_q + lsf_pkg::COUNT_W'(1) : hit_total_q;
	assign len_src    = item_flush ? cnt_q : cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			found_q     <= 1'b0;
			hit_total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_advance) begin
				if (emit) begin
					cnt_q       <= '0;
					found_q     <= 1'b0;
					hit_total_q <= total_next;
				end else if (!item_flush) begin
					cnt_q   <= cnt_inc;
					found_q <= found_q | hit;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_advance && !item_flush) begin
			window_q[0] <= item_byte;
			for (int w = 1; w < WIN_D; w++) begin
				window_q[w] <= window_q[w-1];
			end
		end
		if (emit) begin
			out_data_q.line_length    <= lsf_pkg::LINE_LEN_W'(len_src);
			out_data_q.pattern_found  <= found;
			out_data_q.line_selected  <= sel;
			out_data_q.selected_count <= total_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (cnt_q == '0) && !found_q)
		else $error("line state not cleared after verdict");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LINE_LIMIT))
		else $error("line byte count above limit");

	a_found_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (cnt_q != '0))
		else $error("match flag set with empty line");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		hit_total_q >= $past(hit_total_q))
		else $error("selected line count went down");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !item_advance)
		else $error("result register overwritten while held");

endmodule
